// ----- hdl/stps_pkg.sv -----
package stps_pkg;

	// Fixed field widths of the request and result
	localparam int unsigned SUM_W   = 42;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned END_W   = 11;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned IN_W    = 64;
	localparam int unsigned OUT_W   = 96;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_RANGE  = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WB,
		ST_RNG_CHK,
		ST_RNG_LO,
		ST_RNG_HI,
		ST_RNG_HI_WB,
		ST_FIND_RD,
		ST_FIND_STEP,
		ST_FIND_LEAF,
		ST_EMIT
	} state_t;

	// Result of the shared add / compare-subtract unit
	typedef struct packed {
		logic [SUM_W-1:0] res;
		logic             gt;
	} alu_res_t;

endpackage

// ----- hdl/stps_alu.sv -----
module stps_alu
	import stps_pkg::*;
(
	input  logic [SUM_W-1:0] a,
	input  logic [SUM_W-1:0] b,
	input  logic             sub,
	output alu_res_t         out
);

	logic [SUM_W:0] b_op;
	logic [SUM_W:0] total;

	// One adder: a + b, or a - b through the inverted operand
	always_comb begin
		b_op  = sub ? ~{1'b0, b} : {1'b0, b};
		total = {1'b0, a} + b_op + {{SUM_W{1'b0}}, sub};
		if (sub) begin
			// Top bit set means a borrow, so a < b
			out.res = total[SUM_W-1:0];
			out.gt  = !total[SUM_W] && (total[SUM_W-1:0] != '0);
		end else begin
			// Clamp the sum at the largest node value
			out.res = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
			out.gt  = 1'b0;
		end
	end

endmodule

// ----- hdl/sum_tree_priority_sampler.sv -----
// Sum-tree priority sampler. Holds a binary sum tree over LEAF_COUNT leaf
// priorities (unsigned Q16.16, clamped to LEAF_WIDTH bits; sums clamp at
// 2^42-1) in one on-chip memory of 2*LEAF_COUNT words, plus an append
// counter. Requests: set a leaf, append a leaf, sum a half-open leaf range,
// or find the leaf a prefix-sum target falls in. Each request gives one
// result carrying the grand total and the full flag. After reset the block
// clears all 2*LEAF_COUNT words of the tree and takes no request then.
// One request is handled at a time; tready is high only while idle. Each
// request goes through the tree one level at a time, using the single memory
// read port with registered read data and the one shared add /
// compare-subtract unit.
module sum_tree_priority_sampler
	import stps_pkg::*;
#(
	parameter int unsigned LEAF_COUNT = 1024,
	parameter int unsigned LEAF_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// position[9:0], range_end[20:10], value[62:21], zero[63]
	input  logic [IN_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [CMD_W-1:0] s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// answer[41:0], found_leaf[51:42], grand_total[93:52], zero[95:94]
	output logic [OUT_W-1:0] m_axis_tdata,
	// is_full[0], error[1]
	output logic [1:0]       m_axis_tuser
);

	localparam int unsigned LOG2LC = $clog2(LEAF_COUNT);
	localparam int unsigned AW     = LOG2LC + 1;
	localparam int unsigned NW     = LOG2LC + 2;
	localparam int unsigned CW     = LOG2LC + 1;
	localparam int unsigned DEPTH  = 2 * LEAF_COUNT;

	localparam logic [NW-1:0]    LC_N  = NW'(LEAF_COUNT);
	localparam logic [CW-1:0]    LC_C  = CW'(LEAF_COUNT);
	localparam logic [31:0]      LC_32 = 32'(LEAF_COUNT);
	localparam logic [SUM_W-1:0] LEAF_CAP = (LEAF_WIDTH >= SUM_W) ? SUM_MAX :
		SUM_W'((64'd1 << LEAF_WIDTH) - 64'd1);

	// Request fields
	cmd_t             in_cmd;
	logic [POS_W-1:0] in_pos;
	logic [END_W-1:0] in_end;
	logic [SUM_W-1:0] in_value;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_pos   = s_axis_tdata[9:0];
	assign in_end   = s_axis_tdata[20:10];
	assign in_value = s_axis_tdata[62:21];

	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [CW-1:0]    app_q;
	logic [SUM_W-1:0] root_q;
	logic             out_vld_q;

	cmd_t             cmd_q;
	logic             err_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] tgt_q;
	logic [NW-1:0]    lo_q;
	logic [NW-1:0]    hi_q;

	logic [SUM_W-1:0] out_ans_q;
	logic [POS_W-1:0] out_leaf_q;
	logic [SUM_W-1:0] out_total_q;
	logic             out_full_q;
	logic             out_err_q;

	logic [SUM_W-1:0] node_sums_q [0:DEPTH-1];
	logic [SUM_W-1:0] rdata_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [SUM_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;

	logic             alu_sub;
	logic [SUM_W-1:0] alu_a;
	alu_res_t         alu_out;

	logic             accept;
	logic             full;
	logic             set_ok;
	logic             range_ok;
	logic             emit_load;
	logic [SUM_W-1:0] leaf_clamp;
	logic [NW-1:0]    set_node;
	logic [NW-1:0]    app_node;
	logic [NW-1:0]    hi_dec;
	logic [NW-1:0]    sib_node;
	logic [NW-1:0]    parent_node;
	logic [NW-1:0]    left_node;
	logic [NW-1:0]    leaf_off;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (app_q == LC_C);
	assign set_ok        = {22'd0, in_pos} < LC_32;
	assign range_ok      = ({21'd0, in_end} <= LC_32) && ({1'b0, in_pos} <= in_end);
	assign leaf_clamp    = (in_value > LEAF_CAP) ? LEAF_CAP : in_value;
	assign set_node      = LC_N + NW'(in_pos);
	assign app_node      = LC_N + NW'(app_q);
	assign hi_dec        = hi_q - NW'(1);
	assign sib_node      = {lo_q[NW-1:1], ~lo_q[0]};
	assign parent_node   = lo_q >> 1;
	assign left_node     = {lo_q[NW-2:0], 1'b0};
	assign leaf_off      = lo_q - LC_N;
	assign emit_load     = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready);

	stps_alu u_alu (
		.a   (alu_a),
		.b   (rdata_q),
		.sub (alu_sub),
		.out (alu_out)
	);

	// Tree memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_sums_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= node_sums_q[mem_raddr];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory and shared unit controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = lo_q[AW-1:0];
		alu_sub   = 1'b0;
		alu_a     = acc_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (in_cmd)
						CMD_SET: begin
							if (set_ok) begin
								mem_we    = 1'b1;
								mem_waddr = set_node[AW-1:0];
								mem_wdata = leaf_clamp;
								state_d   = ST_SET_RD;
							end else begin
								state_d = ST_EMIT;
							end
						end
						CMD_APPEND: begin
							if (!full) begin
								mem_we    = 1'b1;
								mem_waddr = app_node[AW-1:0];
								mem_wdata = leaf_clamp;
								state_d   = ST_SET_RD;
							end else begin
								state_d = ST_EMIT;
							end
						end
						CMD_RANGE: state_d = range_ok ? ST_RNG_CHK : ST_EMIT;
						CMD_FIND:  state_d = ST_FIND_RD;
						default:   state_d = ST_EMIT;
					endcase
				end
			end
			ST_SET_RD: begin
				mem_raddr = sib_node[AW-1:0];
				state_d   = (lo_q == NW'(1)) ? ST_EMIT : ST_SET_WB;
			end
			ST_SET_WB: begin
				mem_we    = 1'b1;
				mem_waddr = parent_node[AW-1:0];
				mem_wdata = alu_out.res;
				state_d   = ST_SET_RD;
			end
			ST_RNG_CHK: begin
				if (lo_q >= hi_q) begin
					state_d = ST_EMIT;
				end else if (lo_q[0]) begin
					state_d = ST_RNG_LO;
				end else begin
					state_d = ST_RNG_HI;
				end
			end
			ST_RNG_LO: begin
				state_d = ST_RNG_HI;
			end
			ST_RNG_HI: begin
				mem_raddr = hi_dec[AW-1:0];
				state_d   = hi_q[0] ? ST_RNG_HI_WB : ST_RNG_CHK;
			end
			ST_RNG_HI_WB: begin
				state_d = ST_RNG_CHK;
			end
			ST_FIND_RD: begin
				if (lo_q >= LC_N) begin
					state_d = ST_FIND_LEAF;
				end else begin
					mem_raddr = left_node[AW-1:0];
					state_d   = ST_FIND_STEP;
				end
			end
			ST_FIND_STEP: begin
				alu_sub = 1'b1;
				alu_a   = tgt_q;
				state_d = ST_FIND_RD;
			end
			ST_FIND_LEAF: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_vld_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Clear sweep, append counter, root copy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			app_q     <= '0;
			root_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept && in_cmd == CMD_APPEND && !full) begin
				app_q <= app_q + CW'(1);
			end
			if (mem_we && mem_waddr == AW'(1)) begin
				root_q <= mem_wdata;
			end
			if (emit_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Working registers of the request in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= in_cmd;
					tgt_q <= in_value;
					hi_q  <= LC_N + NW'(in_end);
					acc_q <= (in_cmd == CMD_SET || in_cmd == CMD_APPEND) ? leaf_clamp : '0;
					case (in_cmd)
						CMD_SET: begin
							lo_q  <= set_node;
							err_q <= !set_ok;
						end
						CMD_APPEND: begin
							lo_q  <= app_node;
							err_q <= full;
						end
						CMD_RANGE: begin
							lo_q  <= LC_N + NW'(in_pos);
							err_q <= !range_ok;
						end
						default: begin
							lo_q  <= NW'(1);
							err_q <= 1'b0;
						end
					endcase
				end
			end
			ST_SET_WB: begin
				acc_q <= alu_out.res;
				lo_q  <= parent_node;
			end
			ST_RNG_LO: begin
				acc_q <= alu_out.res;
				lo_q  <= lo_q + NW'(1);
			end
			ST_RNG_HI: begin
				if (hi_q[0]) begin
					hi_q <= hi_dec;
				end else begin
					lo_q <= lo_q >> 1;
					hi_q <= hi_q >> 1;
				end
			end
			ST_RNG_HI_WB: begin
				acc_q <= alu_out.res;
				lo_q  <= lo_q >> 1;
				hi_q  <= hi_q >> 1;
			end
			ST_FIND_STEP: begin
				if (alu_out.gt) begin
					tgt_q <= alu_out.res;
				end
				lo_q <= {lo_q[NW-2:0], alu_out.gt};
			end
			ST_FIND_LEAF: begin
				acc_q <= rdata_q;
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_ans_q   <= (cmd_q == CMD_RANGE || cmd_q == CMD_FIND) ? acc_q : '0;
			out_leaf_q  <= (cmd_q == CMD_FIND) ? leaf_off[POS_W-1:0] : '0;
			out_total_q <= root_q;
			out_full_q  <= full;
			out_err_q   <= err_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_total_q, out_leaf_q, out_ans_q};
	assign m_axis_tuser  = {out_err_q, out_full_q};

endmodule

// ----- hdl/stps_check.sv -----
module stps_check
	import stps_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic [CMD_W-1:0] s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic [1:0]       m_axis_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// One request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// A flagged request gives no answer and no leaf
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[51:0] == 52'd0)
		else $error("error result carries data");

	// Full flag never drops from one valid result cycle to the next
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && $past(m_axis_tvalid) && $past(m_axis_tuser[0]) |->
			m_axis_tuser[0])
		else $error("full flag dropped");

endmodule

bind sum_tree_priority_sampler stps_check u_stps_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_top.sv -----
module tb_top;
	import stps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LEAVES    = 1024;
	localparam int unsigned LEAF_BITS = 32;
	localparam logic [SUM_W-1:0] LEAF_TOP = (42'd1 << LEAF_BITS) - 42'd1;

	typedef struct packed {
		cmd_t             command;
		logic [POS_W-1:0] position;
		logic [END_W-1:0] range_end;
		logic [SUM_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic [SUM_W-1:0] answer;
		logic [POS_W-1:0] found_leaf;
		logic [SUM_W-1:0] grand_total;
		logic             is_full;
		logic             error;
	} outcome_t;

	typedef struct packed {
		request_t req;
		logic     known;
		outcome_t want;
	} table_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0] s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	// Predicted tree, append counter and the results still owed by the block
	logic [SUM_W-1:0] node_total [1:2*LEAVES-1];
	int unsigned      fill_count;
	outcome_t         pending_results[$];
	table_row_t       directed_rows[$];

	int unsigned mismatches;
	int unsigned n_set, n_append, n_range, n_find, n_refused, n_bad_range;
	bit          calm;
	int unsigned hold_request;
	int unsigned hold_left;
	outcome_t    seen;
	outcome_t    want;

	sum_tree_priority_sampler #(
		.LEAF_COUNT(LEAVES),
		.LEAF_WIDTH(LEAF_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #4ns clk = ~clk;

	initial begin
		#6ms;
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sum-tree predictor
	// ------------------------------------------------------------------
	function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	// Clamp the leaf, store it and re-sum every ancestor
	function automatic void write_leaf(int unsigned leaf, logic [SUM_W-1:0] v);
		int unsigned i;
		i = leaf + LEAVES;
		node_total[i] = (v > LEAF_TOP) ? LEAF_TOP : v;
		while (i > 1) begin
			node_total[i >> 1] = sat_sum(node_total[i], node_total[i ^ 1]);
			i = i >> 1;
		end
	endfunction

	// Half-open leaf range, bottom-up
	function automatic logic [SUM_W-1:0] range_total(int unsigned lo, int unsigned hi);
		logic [SUM_W-1:0] acc;
		acc = '0;
		lo += LEAVES;
		hi += LEAVES;
		while (lo < hi) begin
			if ((lo & 1) != 0) begin
				acc = sat_sum(acc, node_total[lo]);
				lo++;
			end
			if ((hi & 1) != 0) begin
				hi--;
				acc = sat_sum(acc, node_total[hi]);
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	// Walk down from the root; ties go left
	function automatic int unsigned descend(logic [SUM_W-1:0] target);
		int unsigned node;
		node = 1;
		while (node < LEAVES) begin
			if (target > node_total[2*node]) begin
				target = target - node_total[2*node];
				node = 2*node + 1;
			end else begin
				node = 2*node;
			end
		end
		return node;
	endfunction

	function automatic outcome_t tree_step(request_t r);
		outcome_t    o;
		int unsigned node;
		o = '0;
		case (r.command)
			CMD_SET: begin
				write_leaf(r.position, r.value);
			end
			CMD_APPEND: begin
				if (fill_count >= LEAVES) begin
					o.error = 1'b1;
				end else begin
					write_leaf(fill_count, r.value);
					fill_count++;
				end
			end
			CMD_RANGE: begin
				if (r.range_end > LEAVES || r.position > r.range_end)
					o.error = 1'b1;
				else
					o.answer = range_total(r.position, r.range_end);
			end
			default: begin
				node = descend(r.value);
				o.answer = node_total[node];
				o.found_leaf = POS_W'(node - LEAVES);
			end
		endcase
		o.grand_total = node_total[1];
		o.is_full = (fill_count >= LEAVES);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [SUM_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SUM_MAX;
			2: return LEAF_TOP;
			3: return SUM_W'($urandom_range(0, 65535));
			4: return SUM_W'({$urandom} << $urandom_range(0, 10));
			5: return SUM_W'(1) << $urandom_range(0, SUM_W-1);
			default: return SUM_W'({$urandom, $urandom});
		endcase
	endfunction

	// Prefix-find target: zero, ties on prefix sums, just past them, overruns, random values
	function automatic logic [SUM_W-1:0] pick_target();
		logic [SUM_W-1:0] t;
		logic [63:0]      wide;
		case ($urandom_range(0, 6))
			0: t = '0;
			1: t = range_total(0, $urandom_range(0, LEAVES));
			2: t = sat_sum(range_total(0, $urandom_range(0, LEAVES)), 42'd1);
			3: t = sat_sum(node_total[1], SUM_W'($urandom_range(1, 1000)));
			4: t = pick_value();
			default: begin
				wide = {$urandom, $urandom};
				t = SUM_W'(wide % ({22'd0, node_total[1]} + 64'd1));
			end
		endcase
		return t;
	endfunction

	function automatic request_t pick_request(int unsigned append_pct);
		request_t    r;
		int unsigned k;
		int unsigned pos;
		k = $urandom_range(0, 99);
		pos = $urandom_range(0, LEAVES-1);
		r.position = POS_W'(pos);
		r.range_end = END_W'($urandom);
		r.value = pick_value();
		if (k < append_pct) begin
			r.command = CMD_APPEND;
		end else begin
			case ((k - append_pct) % 3)
				0: r.command = CMD_SET;
				1: r.command = CMD_RANGE;
				default: r.command = CMD_FIND;
			endcase
		end
		if (r.command == CMD_FIND)
			r.value = pick_target();
		if (r.command == CMD_RANGE) begin
			case ($urandom_range(0, 9))
				0: r.range_end = END_W'(pos);
				1: begin
					r.position = '0;
					r.range_end = END_W'(LEAVES);
				end
				2: r.range_end = END_W'($urandom_range(LEAVES+1, 2047));
				3: r.range_end = (pos == 0) ? END_W'(LEAVES+1) : END_W'($urandom_range(0, pos-1));
				default: r.range_end = END_W'($urandom_range(pos, LEAVES));
			endcase
		end
		return r;
	endfunction

	task automatic add_row(cmd_t c, int unsigned pos, int unsigned stop, logic [SUM_W-1:0] v,
			logic known = 1'b0, logic [SUM_W-1:0] ans = '0, int unsigned leaf = 0,
			logic [SUM_W-1:0] total = '0, logic err = 1'b0);
		table_row_t row;
		row.req = '{command: c, position: POS_W'(pos), range_end: END_W'(stop), value: v};
		row.known = known;
		row.want = '{answer: ans, found_leaf: POS_W'(leaf), grand_total: total,
			is_full: 1'b0, error: err};
		directed_rows.push_back(row);
	endtask

	task automatic report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] exp);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, exp, $time);
	endtask

	// Offer one request after an optional gap, then predict it on acceptance
	task automatic issue(request_t r, logic known, outcome_t typed);
		outcome_t    predicted;
		int unsigned gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 26) begin
			gap = $urandom_range(1, 60);
			repeat (gap) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r.value, r.range_end, r.position};
		s_axis_tuser <= r.command;
		do @(posedge clk); while (!s_axis_tready);
		predicted = tree_step(r);
		pending_results.push_back(known ? typed : predicted);
		case (r.command)
			CMD_SET:    n_set++;
			CMD_APPEND: n_append++;
			CMD_RANGE:  n_range++;
			default:    n_find++;
		endcase
		if (predicted.error) begin
			if (r.command == CMD_APPEND)
				n_refused++;
			else
				n_bad_range++;
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall at random, or hold off when asked
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.answer = m_axis_tdata[41:0];
			seen.found_leaf = m_axis_tdata[51:42];
			seen.grand_total = m_axis_tdata[93:52];
			seen.is_full = m_axis_tuser[0];
			seen.error = m_axis_tuser[1];
			if (pending_results.size() == 0) begin
				report("result with no request pending", seen.answer, '0);
			end else begin
				want = pending_results.pop_front();
				if (seen.answer != want.answer)
					report("answer", seen.answer, want.answer);
				if (seen.found_leaf != want.found_leaf)
					report("found_leaf", SUM_W'(seen.found_leaf), SUM_W'(want.found_leaf));
				if (seen.grand_total != want.grand_total)
					report("grand_total", seen.grand_total, want.grand_total);
				if (seen.is_full != want.is_full)
					report("is_full", SUM_W'(seen.is_full), SUM_W'(want.is_full));
				if (seen.error != want.error)
					report("error", SUM_W'(seen.error), SUM_W'(want.error));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		request_t    r;
		int unsigned n;
		for (int i = 1; i < 2*LEAVES; i++)
			node_total[i] = '0;
		fill_count = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Empty tree, range checks, clamping, ties and overruns
		add_row(CMD_FIND, 0, 0, '0, 1'b1, '0, 0, '0);
		add_row(CMD_FIND, 1023, 2047, SUM_MAX, 1'b1, '0, 1023, '0);
		add_row(CMD_RANGE, 0, LEAVES, '0, 1'b1);
		add_row(CMD_RANGE, 1023, 1023, SUM_MAX, 1'b1);
		add_row(CMD_RANGE, 10, 9, '0, 1'b1, '0, 0, '0, 1'b1);
		add_row(CMD_RANGE, 0, LEAVES+1, '0, 1'b1, '0, 0, '0, 1'b1);
		add_row(CMD_RANGE, 1023, 2047, '0, 1'b1, '0, 0, '0, 1'b1);
		add_row(CMD_SET, 0, 0, SUM_MAX, 1'b1, '0, 0, LEAF_TOP);
		add_row(CMD_SET, 1023, 0, 42'h1_0000, 1'b1, '0, 0, 42'h1_0000_FFFF);
		add_row(CMD_APPEND, 1023, 2047, 42'd5, 1'b1, '0, 0, 42'h1_0005);
		add_row(CMD_APPEND, 0, 0, 42'h100_0000_0000);
		add_row(CMD_FIND, 0, 0, 42'd5);
		add_row(CMD_FIND, 0, 0, 42'd6);
		add_row(CMD_RANGE, 0, 2, '0);
		add_row(CMD_RANGE, 1, LEAVES, SUM_MAX);
		add_row(CMD_FIND, 0, 0, SUM_MAX);
		add_row(CMD_SET, 512, 0, 42'h8000_0000);
		add_row(CMD_FIND, 0, 0, 42'h1_0000_0004);
		add_row(CMD_FIND, 0, 0, 42'h1_0000_0005);
		add_row(CMD_RANGE, 0, LEAVES, '0);
		add_row(CMD_SET, 0, 0, '0);
		add_row(CMD_RANGE, 512, 513, '0);
		add_row(CMD_FIND, 0, 0, '0);
		add_row(CMD_RANGE, 0, 0, SUM_MAX);
		foreach (directed_rows[i])
			issue(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

		// Fill the tree mostly by appends, with the other commands mixed in
		n = 0;
		while (fill_count < LEAVES) begin
			calm = (n >= 200 && n < 360);
			if (n == 500)
				hold_request = 400;
			r = pick_request(85);
			issue(r, 1'b0, '0);
			n++;
		end
		calm = 1'b0;

		// Full tree: refused appends, sets, ranges and finds
		repeat (100) begin
			r = pick_request(25);
			issue(r, 1'b0, '0);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);

		$display("Ran %0d set, %0d append, %0d range-sum and %0d prefix-find requests;",
			n_set, n_append, n_range, n_find);
		$display("%0d appends refused on a full tree, %0d bad ranges, %0d field mismatches.",
			n_refused, n_bad_range, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/stps_pkg.sv
hdl/stps_alu.sv
hdl/sum_tree_priority_sampler.sv
hdl/stps_check.sv
dv/tb_top.sv
